[src/tun_pkg.sv]
// tun_pkg: widths, lane types and stage records for the triangle unit normal pipeline.
// No dependencies; used by tun_if.sv and triangle_unit_normal.sv.
package tun_pkg;

  localparam int CW   = 16;   // Q8.8 coordinate
  localparam int EW   = 17;   // edge component, Q9.8
  localparam int XW   = 34;   // edge product
  localparam int VW   = 35;   // cross product component, signed
  localparam int MW   = 34;   // cross product magnitude
  localparam int HW   = 17;   // half of a magnitude for squaring
  localparam int SQW  = 2 * HW;
  localparam int M2W  = 67;   // magnitude squared
  localparam int SW   = 68;   // sum of squares
  localparam int FRAC = 30;   // 2^30 scale on the squared numerator
  localparam int RW   = 102;  // remainder of the root search, signed
  localparam int TW   = 86;   // (2r-1) * sum of squares, signed
  localparam int QW   = 15;   // result magnitude 0..16384
  localparam int NW   = 16;   // Q1.14 output
  localparam int NORM_ONE = 16384;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [XW-1:0] xprod_t;
  typedef logic signed [NW-1:0] norm_t;

  typedef struct packed {
    logic signed [RW-1:0] rem;
    logic signed [TW-1:0] tprod;
    logic [QW-1:0]        q;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   lane;
    logic [SW-1:0] sumsq;
    logic [2:0]    neg;
    logic          degen;
  } iter_t;

endpackage

[src/tun_if.sv]
// tun_if: valid/ready channels for triangle vertices and unit normals.
// Depends on tun_pkg.
interface tun_vtx_if;
  logic valid;
  logic ready;
  tun_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_nrm_if;
  logic valid;
  logic ready;
  tun_pkg::norm_t normal_x, normal_y, normal_z;
  logic degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

[src/triangle_unit_normal.sv]
// triangle_unit_normal: pipelined unit face normal (cross product, exact rounded normalize).
// Depends on tun_pkg and tun_if.
//
//   channel  dir  payload                                        handshake
//   vtx      in   ax ay az bx by bz cx cy cz (Q8.8)              valid/ready
//   nrm      out  normal_x normal_y normal_z (Q1.14), degenerate valid/ready
//
// One triangle per cycle while nrm is not stalled.
// Depth is set by the 15-stage shift/subtract root search, one result bit per stage.
// rst (synchronous) clears all stage valid bits; payload is not reset.
// A stall on nrm freezes every stage at once; vtx.ready drops for that cycle.
module triangle_unit_normal (
  input logic       clk,
  input logic       rst,
  tun_vtx_if.sink   vtx,
  tun_nrm_if.source nrm
);

  localparam int NS = tun_pkg::QW;

  logic en;
  assign en = !nrm.valid || nrm.ready;
  assign vtx.ready = en;

  // stage 1: edges
  logic v1;
  tun_pkg::edge_t e1 [3];
  tun_pkg::edge_t e2 [3];
  // stage 2: edge products
  logic v2;
  tun_pkg::xprod_t pa [3];
  tun_pkg::xprod_t pb [3];
  // stage 3: cross product magnitude and sign
  logic v3;
  logic [tun_pkg::MW-1:0] mag [3];
  logic [2:0] neg3, neg4, neg5;
  // stage 4: partial squares
  logic v4;
  logic [tun_pkg::SQW-1:0] shh [3];
  logic [tun_pkg::SQW-1:0] shl [3];
  logic [tun_pkg::SQW-1:0] sll [3];
  // stage 5: squares
  logic v5;
  logic [tun_pkg::M2W-1:0] m2 [3];
  // root search stages
  logic         iv [NS+1];
  tun_pkg::iter_t it [NS+1];

  logic signed [tun_pkg::VW-1:0] vc [3];
  logic [tun_pkg::SW-1:0] sum_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vc[i] = tun_pkg::VW'(pa[i]) - tun_pkg::VW'(pb[i]);
    end
    sum_c = tun_pkg::SW'(m2[0]) + tun_pkg::SW'(m2[1]) + tun_pkg::SW'(m2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      iv[0] <= 1'b0;
    end else if (en) begin
      v1 <= vtx.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      iv[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= tun_pkg::EW'(vtx.bx) - tun_pkg::EW'(vtx.ax);
      e1[1] <= tun_pkg::EW'(vtx.by) - tun_pkg::EW'(vtx.ay);
      e1[2] <= tun_pkg::EW'(vtx.bz) - tun_pkg::EW'(vtx.az);
      e2[0] <= tun_pkg::EW'(vtx.cx) - tun_pkg::EW'(vtx.ax);
      e2[1] <= tun_pkg::EW'(vtx.cy) - tun_pkg::EW'(vtx.ay);
      e2[2] <= tun_pkg::EW'(vtx.cz) - tun_pkg::EW'(vtx.az);

      pa[0] <= e1[1] * e2[2];
      pb[0] <= e1[2] * e2[1];
      pa[1] <= e1[2] * e2[0];
      pb[1] <= e1[0] * e2[2];
      pa[2] <= e1[0] * e2[1];
      pb[2] <= e1[1] * e2[0];

      for (int i = 0; i < 3; i++) begin
        neg3[i] <= vc[i][tun_pkg::VW-1];
        mag[i] <= vc[i][tun_pkg::VW-1] ? tun_pkg::MW'(-vc[i]) : tun_pkg::MW'(vc[i]);

        shh[i] <= mag[i][tun_pkg::MW-1 -: tun_pkg::HW] * mag[i][tun_pkg::MW-1 -: tun_pkg::HW];
        shl[i] <= mag[i][tun_pkg::MW-1 -: tun_pkg::HW] * mag[i][tun_pkg::HW-1:0];
        sll[i] <= mag[i][tun_pkg::HW-1:0] * mag[i][tun_pkg::HW-1:0];

        m2[i] <= (tun_pkg::M2W'(shh[i]) << (2 * tun_pkg::HW))
               + (tun_pkg::M2W'(shl[i]) << (tun_pkg::HW + 1))
               + tun_pkg::M2W'(sll[i]);

        it[0].lane[i].rem <= $signed(tun_pkg::RW'(m2[i]) << tun_pkg::FRAC)
                           - $signed(tun_pkg::RW'(sum_c));
        it[0].lane[i].tprod <= -$signed(tun_pkg::TW'(sum_c));
        it[0].lane[i].q <= '0;
      end
      neg4 <= neg3;
      neg5 <= neg4;
      it[0].neg <= neg5;
      it[0].sumsq <= sum_c;
      it[0].degen <= (sum_c == '0);
    end
  end

  // one result bit per stage, most significant first
  for (genvar j = 0; j < NS; j++) begin : g_root
    localparam int K = NS - 1 - j;
    tun_pkg::iter_t nx;

    always_comb begin
      nx = it[j];
      for (int l = 0; l < 3; l++) begin
        logic signed [tun_pkg::RW-1:0] trial;
        trial = it[j].lane[l].rem
              - ((tun_pkg::RW'(it[j].lane[l].tprod) <<< (K + 2))
                 + $signed(tun_pkg::RW'(it[j].sumsq) << (2 * K + 2)));
        if (!trial[tun_pkg::RW-1]) begin
          nx.lane[l].rem = trial;
          nx.lane[l].tprod = it[j].lane[l].tprod
                           + $signed(tun_pkg::TW'(it[j].sumsq) << (K + 1));
          nx.lane[l].q[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        iv[j+1] <= 1'b0;
      end else if (en) begin
        iv[j+1] <= iv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[j+1] <= nx;
      end
    end
  end

  tun_pkg::norm_t res [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      res[l] = tun_pkg::NW'(it[NS].lane[l].q);
      if (it[NS].degen) begin
        res[l] = '0;
      end else if (it[NS].neg[l]) begin
        res[l] = -res[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm.valid <= 1'b0;
    end else if (en) begin
      nrm.valid <= iv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm.normal_x <= res[0];
      nrm.normal_y <= res[1];
      nrm.normal_z <= res[2];
      nrm.degenerate <= it[NS].degen;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    nrm.valid && nrm.degenerate |->
      nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    nrm.valid |->
      nrm.normal_x <= tun_pkg::NW'(tun_pkg::NORM_ONE)
      && nrm.normal_x >= -tun_pkg::NW'(tun_pkg::NORM_ONE)
      && nrm.normal_y <= tun_pkg::NW'(tun_pkg::NORM_ONE)
      && nrm.normal_y >= -tun_pkg::NW'(tun_pkg::NORM_ONE)
      && nrm.normal_z <= tun_pkg::NW'(tun_pkg::NORM_ONE)
      && nrm.normal_z >= -tun_pkg::NW'(tun_pkg::NORM_ONE))
    else $error("normal component out of range");

  a_reset_idle: assert property (@(posedge clk) rst |=> !nrm.valid && !v1)
    else $error("valid survived reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    nrm.valid && !nrm.ready |-> !vtx.ready)
    else $error("input taken while output stalled");

endmodule
